/* hdl/tem_pkg.sv */
// Package for the text extent measure block: payload structs, op and status codes,
// and the command and status structs between the controller and the datapath.
// No dependencies.
package tem_pkg;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_GLYPH = 3'd1;
  localparam logic [2:0] OP_KERN  = 3'd2;
  localparam logic [2:0] OP_BYTE  = 3'd3;
  localparam logic [2:0] OP_END   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MEAS    = 2'd2;
  localparam logic [1:0] ST_NOGLYPH = 2'd3;

  localparam logic [7:0] NEWLINE = 8'd10;

  localparam logic [1:0] REG_BASELINE = 2'd0;
  localparam logic [1:0] REG_LINE_H   = 2'd1;
  localparam logic [1:0] REG_SCALE    = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] code;
    logic [31:0] second_code;
    logic [15:0] glyph_width;
    logic [15:0] glyph_height;
    logic signed [15:0] glyph_off_x;
    logic signed [15:0] glyph_off_y;
    logic signed [15:0] glyph_step;
    logic signed [15:0] kern_amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] width_scaled;
    logic [47:0] height_scaled;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_item;   // capture the input item
    logic clear;       // empty both tables
    logic wr_glyph;    // write glyph entry at the count
    logic wr_kern;     // write kerning entry at the count
    logic scan_start;  // reset the search index
    logic scan_step;   // examine one entry of each table
    logic place;       // place glyph or handle newline
    logic measure;     // reset pen, box and text state
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic glyph_full;
    logic kern_full;
    logic scan_done;
    logic any_glyph;
  } dp_stat_t;

endpackage

/* hdl/tem_datapath.sv */
// Datapath of the text extent measure block: glyph and kerning memories, search
// index, pen and box registers, and the scaling multiplier. Uses tem_pkg.
module tem_datapath #(
  parameter int MAX_GLYPHS   = 256,
  parameter int MAX_KERNINGS = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tem_pkg::in_item_t     item,
  input  tem_pkg::dp_cmd_t      cmd,
  input  logic signed [15:0]    baseline,
  input  logic [14:0]           line_pitch,
  input  logic [15:0]           scale_factor,
  output tem_pkg::dp_stat_t     stat,
  output logic [47:0]           width_scaled,
  output logic [47:0]           height_scaled
);
  import tem_pkg::*;

  localparam int GW = $clog2(MAX_GLYPHS + 1);
  localparam int KW = $clog2(MAX_KERNINGS + 1);
  localparam int GA = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int KA = (MAX_KERNINGS > 1) ? $clog2(MAX_KERNINGS) : 1;
  localparam int MAXN = (MAX_GLYPHS > MAX_KERNINGS) ? MAX_GLYPHS : MAX_KERNINGS;
  localparam int SW = $clog2(MAXN + 2);
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Glyph entry: id, width, height, off_x, off_y, advance.
  logic [111:0] gmem [MAX_GLYPHS];
  // Kerning entry: first, second, amount.
  logic [79:0]  kmem [MAX_KERNINGS];
  logic [111:0] grd;
  logic [79:0]  krd;

  in_item_t      it;
  logic [GW-1:0] glyph_count;
  logic [KW-1:0] kern_count;
  logic [SW-1:0] idx;      // address being read
  logic [SW-1:0] ridx;     // address of the registered read data
  logic          rvalid;
  logic          gfound, kfound;
  logic [111:0]  gsel;
  logic signed [15:0] kern;
  logic signed [31:0] pen_x, pen_y;
  logic [7:0]    prev_byte;
  logic signed [31:0] box_min_x, box_max_x, box_min_y, box_max_y;
  logic          any_glyph;
  logic [32:0]   w33, h33;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return S32_MAX;
    if (v < -35'sd2147483648) return S32_MIN;
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.wr_glyph)
      gmem[glyph_count[GA-1:0]] <= {it.code, it.glyph_width, it.glyph_height,
                                    it.glyph_off_x, it.glyph_off_y, it.glyph_step};
    if (cmd.wr_kern)
      kmem[kern_count[KA-1:0]] <= {it.code, it.second_code, it.kern_amount};
    grd <= gmem[idx[GA-1:0]];
    krd <= kmem[idx[KA-1:0]];
  end

  logic        g_hit, k_hit;
  assign g_hit = rvalid && !gfound && (ridx < SW'(glyph_count))
                 && (grd[111:80] == {24'd0, it.code[7:0]});
  assign k_hit = rvalid && !kfound && (ridx < SW'(kern_count))
                 && (krd[79:48] == {24'd0, prev_byte})
                 && (krd[47:16] == {24'd0, it.code[7:0]});

  // Placement arithmetic, one add chain on 35-bit values.
  logic signed [34:0] x0, y1;
  assign x0 = 35'(pen_x) + 35'(signed'(gsel[47:32])) + 35'(kern);
  assign y1 = 35'(pen_y) + 35'(baseline) - 35'(signed'(gsel[31:16]));

  always_ff @(posedge clk) begin
    if (cmd.load_item) it <= item;
    if (rst) begin
      glyph_count <= '0;
      kern_count  <= '0;
      idx <= '0; ridx <= '0; rvalid <= 1'b0;
      gfound <= 1'b0; kfound <= 1'b0;
      pen_x <= '0; pen_y <= '0; prev_byte <= '0;
      box_min_x <= S32_MAX; box_max_x <= S32_MIN;
      box_min_y <= S32_MAX; box_max_y <= S32_MIN;
      any_glyph <= 1'b0;
    end else begin
      if (cmd.clear) begin
        glyph_count <= '0;
        kern_count  <= '0;
      end
      if (cmd.wr_glyph) glyph_count <= glyph_count + 1'b1;
      if (cmd.wr_kern)  kern_count  <= kern_count + 1'b1;
      if (cmd.scan_start) begin
        idx <= '0; rvalid <= 1'b0; gfound <= 1'b0; kfound <= 1'b0;
        kern <= '0;
      end
      if (cmd.scan_step) begin
        idx    <= idx + 1'b1;
        ridx   <= idx;
        rvalid <= 1'b1;
        if (g_hit) begin
          gfound <= 1'b1;
          gsel   <= grd;
        end
        if (k_hit) begin
          kfound <= 1'b1;
          kern   <= signed'(krd[15:0]);
        end
      end
      if (cmd.place) begin
        if (gfound) begin
          if (sat32(x0) < box_min_x) box_min_x <= sat32(x0);
          if (sat32(x0 + 35'(gsel[79:64])) > box_max_x)
            box_max_x <= sat32(x0 + 35'(gsel[79:64]));
          if (sat32(y1) > box_max_y) box_max_y <= sat32(y1);
          if (sat32(y1 - 35'(gsel[63:48])) < box_min_y)
            box_min_y <= sat32(y1 - 35'(gsel[63:48]));
          any_glyph <= 1'b1;
          pen_x <= sat32(35'(pen_x) + 35'(signed'(gsel[15:0])));
        end else if (it.code[7:0] == NEWLINE) begin
          pen_x <= '0;
          pen_y <= sat32(35'(pen_y) - 35'(line_pitch));
        end
        prev_byte <= it.code[7:0];
      end
      if (cmd.measure) begin
        pen_x <= '0; pen_y <= '0; prev_byte <= '0;
        box_min_x <= S32_MAX; box_max_x <= S32_MIN;
        box_min_y <= S32_MAX; box_max_y <= S32_MIN;
        any_glyph <= 1'b0;
      end
    end
  end

  // Box extents are nonnegative when any glyph was placed; 33 x 16 fits 49 bits.
  assign w33 = 33'(box_max_x) - 33'(box_min_x);
  assign h33 = 33'(box_max_y) - 33'(box_min_y);
  logic [48:0] wprod, hprod;
  assign wprod = w33 * scale_factor;
  assign hprod = h33 * scale_factor;
  assign width_scaled  = any_glyph ? wprod[47:0] : '0;
  assign height_scaled = any_glyph ? hprod[47:0] : '0;

  assign stat.glyph_full = (glyph_count >= GW'(MAX_GLYPHS));
  assign stat.kern_full  = (kern_count >= KW'(MAX_KERNINGS));
  assign stat.scan_done  = (ridx >= SW'(MAXN - 1)) && rvalid;
  assign stat.any_glyph  = any_glyph;

endmodule

/* hdl/tem_ctrl.sv */
// Controller of the text extent measure block: sequences table loads, the table
// search for each text byte, and the end-of-text measurement. Uses tem_pkg.
module tem_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_op,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic                out_load,
  output tem_pkg::dp_cmd_t    cmd,
  input  tem_pkg::dp_stat_t   stat
);
  import tem_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PLACE, S_OUT} state_t;
  state_t state;
  logic [2:0] op;

  assign in_ready = (state == S_IDLE) && !out_valid;
  logic acc;
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.load_item  = acc;
    cmd.scan_start = acc;
    cmd.scan_step  = (state == S_SCAN);
    cmd.place      = (state == S_PLACE);
    cmd.measure    = (state == S_OUT) && out_ready && (op == OP_END) && out_valid;
    cmd.clear      = (state == S_OUT) && (op == OP_CLEAR) && out_valid && out_ready;
    cmd.wr_glyph   = (state == S_OUT) && (op == OP_GLYPH) && !stat.glyph_full
                     && out_valid && out_ready;
    cmd.wr_kern    = (state == S_OUT) && (op == OP_KERN) && !stat.kern_full
                     && out_valid && out_ready;
  end

  // The result is presented from live datapath state; the table write and the
  // text reset happen with the output beat.
  always_comb begin
    out_load = 1'b0;
    case (op)
      OP_GLYPH: out_status = stat.glyph_full ? ST_FULL : ST_OK;
      OP_KERN:  out_status = stat.kern_full ? ST_FULL : ST_OK;
      OP_END: begin
        out_status = stat.any_glyph ? ST_MEAS : ST_NOGLYPH;
        out_load = 1'b1;
      end
      default:  out_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      op <= OP_CLEAR;
    end else begin
      case (state)
        S_IDLE: if (acc) begin
          op <= in_op;
          if (in_op == OP_BYTE) state <= S_SCAN;
          else begin
            state <= S_OUT;
            out_valid <= 1'b1;
          end
        end
        S_SCAN: if (stat.scan_done) state <= S_PLACE;
        S_PLACE: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/text_extent_measure_core.sv */
// Text extent measure: bounding box of text in a bitmap font, scaled on end of text.
// A text byte is handled by a linear search that reads one glyph and one kerning
// entry a cycle over the larger table; other ops skip the search.
// One item at a time; the result beat must be taken before the next item.
// Synchronous reset clears counts, pen, box, baseline and line pitch and sets scale
// to 256; table memories are not cleared and only match below the fill counts.
module text_extent_measure_core #(
  parameter int MAX_GLYPHS   = 256,
  parameter int MAX_KERNINGS = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tem_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tem_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tem_pkg::*;

  logic signed [15:0] baseline;
  logic [14:0] line_pitch;
  logic [15:0] scale_factor;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [1:0] status;
  logic out_load;
  logic [47:0] wsc, hsc;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline <= '0;
      line_pitch <= '0;
      scale_factor <= 16'd256;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_BASELINE: baseline <= pwdata[15:0];
        REG_LINE_H:   line_pitch <= pwdata[14:0];
        REG_SCALE:    scale_factor <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BASELINE: prdata = {16'd0, baseline};
      REG_LINE_H:   prdata = {17'd0, line_pitch};
      REG_SCALE:    prdata = {16'd0, scale_factor};
      default:      prdata = '0;
    endcase
  end

  tem_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_op(in_data.op),
    .out_valid, .out_ready, .out_status(status), .out_load, .cmd, .stat
  );

  tem_datapath #(.MAX_GLYPHS(MAX_GLYPHS), .MAX_KERNINGS(MAX_KERNINGS)) u_dp (
    .clk, .rst, .item(in_data), .cmd, .baseline, .line_pitch, .scale_factor,
    .stat, .width_scaled(wsc), .height_scaled(hsc)
  );

  assign out_data.status        = status;
  assign out_data.width_scaled  = out_load ? wsc : '0;
  assign out_data.height_scaled = out_load ? hsc : '0;

endmodule

/* hdl/tem_checker.sv */
// Port-level checker for the text extent measure block, bound to the top level.
// Uses tem_pkg for status codes.
module tem_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tem_pkg::out_item_t out_data
);
  import tem_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while a result waits");

  a_zero_unless_measured: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_MEAS |->
      out_data.width_scaled == '0 && out_data.height_scaled == '0)
    else $error("nonzero size without a measurement");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

endmodule

bind text_extent_measure_core tem_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Testbench for text_extent_measure_core: directed rows, then random font and text phases,
// all checked beat by beat against an in-bench glyph/kerning box predictor.
// Depends on tem_pkg and text_extent_measure_core.
module testbench;
  import tem_pkg::*;

  localparam int GLYPH_SLOTS = 256;
  localparam int KERN_SLOTS  = 512;
  localparam int ITEM_TARGET = 1170;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       psel = 1'b0;
  logic       penable = 1'b0;
  logic       pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic       pready;

  text_extent_measure_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Font tables and text state as the block should hold them.
  logic [31:0]        font_id    [GLYPH_SLOTS];
  logic [15:0]        font_w     [GLYPH_SLOTS];
  logic [15:0]        font_h     [GLYPH_SLOTS];
  logic signed [15:0] font_ox    [GLYPH_SLOTS];
  logic signed [15:0] font_oy    [GLYPH_SLOTS];
  logic signed [15:0] font_adv   [GLYPH_SLOTS];
  int                 font_count;
  logic [63:0]        pair_key   [KERN_SLOTS];
  logic signed [15:0] pair_shift [KERN_SLOTS];
  int                 pair_count;
  int                 pen_x, pen_y;
  logic [7:0]         last_byte;
  int                 edge_lo_x, edge_hi_x, edge_lo_y, edge_hi_y;
  bit                 placed_any;
  logic signed [15:0] baseline_reg;
  logic [14:0]        line_step_reg;
  logic [15:0]        scale_reg;

  out_item_t pending_boxes[$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        beats_seen = 0;
  int        cycle_no = 0;
  bit        rx_hold = 1'b0;
  int        hold_cnt = 0;

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic void clear_text();
    pen_x = 0;
    pen_y = 0;
    last_byte = '0;
    edge_lo_x = 32'sh7fffffff;
    edge_hi_x = 32'sh80000000;
    edge_lo_y = 32'sh7fffffff;
    edge_hi_y = 32'sh80000000;
    placed_any = 1'b0;
  endfunction

  function automatic void place_char(logic [7:0] b);
    longint kern, x0, y1;
    int gi, lx, hx, ly, hy;
    kern = 0;
    for (int k = 0; k < pair_count; k++) begin
      if (pair_key[k] == {24'd0, last_byte, 24'd0, b}) begin
        kern = longint'(pair_shift[k]);
        break;
      end
    end
    gi = -1;
    for (int g = 0; g < font_count; g++) begin
      if (font_id[g] == {24'd0, b}) begin
        gi = g;
        break;
      end
    end
    if (gi >= 0) begin
      x0 = longint'(pen_x) + longint'(font_ox[gi]) + kern;
      y1 = longint'(pen_y) + longint'(baseline_reg) - longint'(font_oy[gi]);
      lx = clamp32(x0);
      hx = clamp32(x0 + longint'(font_w[gi]));
      hy = clamp32(y1);
      ly = clamp32(y1 - longint'(font_h[gi]));
      if (lx < edge_lo_x) edge_lo_x = lx;
      if (hx > edge_hi_x) edge_hi_x = hx;
      if (hy > edge_hi_y) edge_hi_y = hy;
      if (ly < edge_lo_y) edge_lo_y = ly;
      placed_any = 1'b1;
      pen_x = clamp32(longint'(pen_x) + longint'(font_adv[gi]));
    end else if (b == NEWLINE) begin
      pen_x = 0;
      pen_y = clamp32(longint'(pen_y) - longint'(line_step_reg));
    end
    last_byte = b;
  endfunction

  function automatic out_item_t predict_box(in_item_t it);
    out_item_t r;
    longint unsigned span_x, span_y;
    r = '0;
    r.status = ST_OK;
    case (it.op)
      OP_CLEAR: begin
        font_count = 0;
        pair_count = 0;
      end
      OP_GLYPH: begin
        if (font_count < GLYPH_SLOTS) begin
          font_id[font_count]  = it.code;
          font_w[font_count]   = it.glyph_width;
          font_h[font_count]   = it.glyph_height;
          font_ox[font_count]  = it.glyph_off_x;
          font_oy[font_count]  = it.glyph_off_y;
          font_adv[font_count] = it.glyph_step;
          font_count++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_KERN: begin
        if (pair_count < KERN_SLOTS) begin
          pair_key[pair_count]   = {it.code, it.second_code};
          pair_shift[pair_count] = it.kern_amount;
          pair_count++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_BYTE: place_char(it.code[7:0]);
      OP_END: begin
        if (placed_any) begin
          span_x = longint'(edge_hi_x) - longint'(edge_lo_x);
          span_y = longint'(edge_hi_y) - longint'(edge_lo_y);
          r.width_scaled  = 48'(span_x * longint'(scale_reg));
          r.height_scaled = 48'(span_y * longint'(scale_reg));
          r.status = ST_MEAS;
        end else begin
          r.status = ST_NOGLYPH;
        end
        clear_text();
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t mk(logic [2:0] op, logic [31:0] code, logic [31:0] code2,
                                  logic [15:0] w, logic [15:0] h, logic [15:0] ox,
                                  logic [15:0] oy, logic [15:0] step, logic [15:0] kern);
    in_item_t it;
    it.op = op;
    it.code = code;
    it.second_code = code2;
    it.glyph_width = w;
    it.glyph_height = h;
    it.glyph_off_x = ox;
    it.glyph_off_y = oy;
    it.glyph_step = step;
    it.kern_amount = kern;
    return it;
  endfunction

  // Random filler for the fields that an op does not use.
  function automatic in_item_t noise_fields(in_item_t it, bit keep_load);
    in_item_t r;
    r = it;
    if (!keep_load) begin
      r.second_code = $urandom;
      r.glyph_width = 16'($urandom);
      r.glyph_height = 16'($urandom);
      r.glyph_off_x = 16'($urandom);
      r.glyph_off_y = 16'($urandom);
      r.glyph_step = 16'($urandom);
    end
    r.kern_amount = (it.op == OP_KERN) ? it.kern_amount : 16'($urandom);
    return r;
  endfunction

  // Keeps valid high unless this beat is preceded by an idle gap.
  task automatic offer(in_item_t it, bit has_want, out_item_t want);
    out_item_t got;
    if (!(items_sent >= 300 && items_sent < 420) && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    got = predict_box(it);
    pending_boxes.push_back(has_want ? want : got);
    items_sent++;
  endtask

  task automatic send(in_item_t it);
    offer(it, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    // Every item yields a beat, so the block is idle once the queue is empty.
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BASELINE: baseline_reg = val[15:0];
      REG_LINE_H:   line_step_reg = val[14:0];
      REG_SCALE:    scale_reg = val[15:0];
      default: ;
    endcase
  endtask

  task automatic report(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s at beat %0d: expected st=%0d w=%0h h=%0h, got st=%0d w=%0h h=%0h",
               what, beats_seen, want.status, want.width_scaled, want.height_scaled,
               got.status, got.width_scaled, got.height_scaled);
  endtask

  // Result side: checks each beat; stalls at random, always in the hold, never in a set window.
  always @(posedge clk) begin
    out_item_t want;
    cycle_no <= cycle_no + 1;
    if (!rst && out_valid && out_ready) begin
      beats_seen <= beats_seen + 1;
      if (pending_boxes.size() == 0) begin
        report("unexpected beat", '0, out_data);
      end else begin
        want = pending_boxes.pop_front();
        if (out_data.status != want.status) report("status", want, out_data);
        else if (out_data.width_scaled != want.width_scaled) report("width", want, out_data);
        else if (out_data.height_scaled != want.height_scaled) report("height", want, out_data);
      end
    end
    if (rx_hold) begin
      out_ready <= 1'b0;
    end else if (cycle_no >= 20000 && cycle_no < 40000) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 35);
    end
  end

  // Holds off the result side once for a long stretch after the 150th beat.
  always @(posedge clk) begin
    if (rx_hold) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 400) rx_hold <= 1'b0;
    end else if (beats_seen == 150 && hold_cnt == 0) begin
      rx_hold <= 1'b1;
    end
  end

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } row_t;

  function automatic out_item_t res(logic [1:0] st, logic [47:0] w, logic [47:0] h);
    out_item_t r;
    r.status = st;
    r.width_scaled = w;
    r.height_scaled = h;
    return r;
  endfunction

  initial begin
    row_t rows[$];
    logic [31:0] ids[$];
    in_item_t it;
    int n, phase;
    logic [7:0] b;

    clear_text();
    font_count = 0;
    pair_count = 0;
    baseline_reg = '0;
    line_step_reg = '0;
    scale_reg = 16'd256;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back('{mk(OP_END, 0, 0, 0, 0, 0, 0, 0, 0), 1, res(ST_NOGLYPH, 0, 0)});
    rows.push_back('{mk(3'd5, 32'hffffffff, '1, '1, '1, '1, '1, '1, '1), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(3'd7, 65, 0, 0, 0, 0, 0, 0, 0), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(3'd6, 0, 0, 0, 0, 0, 0, 0, 0), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(OP_GLYPH, 65, 0, 10, 20, 0, 0, 12, 0), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(OP_GLYPH, 0, '1, 16'hffff, 16'hffff, 16'h8000, 16'h7fff, 16'h7fff,
                        0), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(OP_GLYPH, 32'hffffffff, 0, 1, 1, 0, 0, 0, 0), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(OP_KERN, 0, 65, 0, 0, 0, 0, 0, 16'h8000), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(OP_KERN, 65, 65, 0, 0, 0, 0, 0, 16'h7fff), 1, res(ST_OK, 0, 0)});
    // A lone glyph: the box is its own size whatever the kerning shift.
    rows.push_back('{mk(OP_BYTE, 65, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_END, 0, 0, 0, 0, 0, 0, 0, 0), 1, res(ST_MEAS, 48'd2560, 48'd5120)});
    rows.push_back('{mk(OP_BYTE, 65, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_BYTE, 32'hffffff41, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_BYTE, NEWLINE, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_BYTE, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_BYTE, 200, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_END, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(OP_BYTE, 65, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_END, 0, 0, 0, 0, 0, 0, 0, 0), 1, res(ST_NOGLYPH, 0, 0)});
    foreach (rows[i]) offer(rows[i].it, rows[i].typed, rows[i].want);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(2) == 0 || phase < 3) begin
        drain();
        case (phase % 4)
          0: reg_write(REG_BASELINE, 32'hffff8000);
          1: reg_write(REG_BASELINE, 32'h00007fff);
          default: reg_write(REG_BASELINE, $urandom);
        endcase
        case (phase % 3)
          0: reg_write(REG_LINE_H, 32'h7fff);
          1: reg_write(REG_LINE_H, 0);
          default: reg_write(REG_LINE_H, $urandom);
        endcase
        case (phase % 5)
          0: reg_write(REG_SCALE, 32'hffff);
          1: reg_write(REG_SCALE, 0);
          2: reg_write(REG_SCALE, 256);
          default: reg_write(REG_SCALE, $urandom);
        endcase
      end
      if (phase == 4 || $urandom_range(2) == 0 || font_count > 200 || pair_count > 400) begin
        send(noise_fields(mk(OP_CLEAR, $urandom, 0, 0, 0, 0, 0, 0, 0), 0));
        ids.delete();
      end
      if (phase == 4) begin
        // Overfill both tables so that the extra loads are dropped.
        n = GLYPH_SLOTS + 3;
        for (int g = 0; g < n; g++) begin
          it = mk(OP_GLYPH, $urandom_range(255), 0, 16'($urandom_range(40)),
                  16'($urandom_range(40)),
                  16'($urandom_range(20)) - 16'd10, 16'($urandom_range(20)) - 16'd10,
                  16'($urandom_range(30)), 0);
          send(noise_fields(it, 1));
        end
        for (int k = 0; k < KERN_SLOTS + 3; k++) begin
          it = mk(OP_KERN, $urandom_range(255), $urandom_range(255), 0, 0, 0, 0, 0,
                  16'($urandom_range(20)) - 16'd10);
          send(noise_fields(it, 1));
        end
        for (int g = 0; g < 256; g++) ids.push_back(g);
      end else begin
        n = $urandom_range(8);
        for (int g = 0; g < n; g++) begin
          it = mk(OP_GLYPH, ($urandom_range(9) < 8) ? $urandom_range(255) : $urandom,
                  0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 0);
          if ($urandom_range(1)) begin
            it.glyph_width = 16'($urandom_range(64));
            it.glyph_height = 16'($urandom_range(64));
            it.glyph_off_x = 16'($urandom_range(32)) - 16'd16;
            it.glyph_off_y = 16'($urandom_range(32)) - 16'd16;
            it.glyph_step = 16'($urandom_range(48)) - 16'd8;
          end
          ids.push_back(it.code);
          send(noise_fields(it, 1));
        end
        n = $urandom_range(8);
        for (int k = 0; k < n; k++) begin
          it = mk(OP_KERN, ($urandom_range(9) < 8) ? $urandom_range(255) : $urandom,
                  ($urandom_range(9) < 8) ? $urandom_range(255) : $urandom,
                  0, 0, 0, 0, 0, 16'($urandom));
          if (ids.size() != 0 && $urandom_range(1)) begin
            it.code = ids[$urandom_range(ids.size() - 1)] & 32'hff;
            it.second_code = ids[$urandom_range(ids.size() - 1)] & 32'hff;
          end
          send(noise_fields(it, 1));
        end
      end
      n = $urandom_range(3, 16);
      for (int t = 0; t < n; t++) begin
        case ($urandom_range(9))
          0:       b = NEWLINE;
          1:       b = 8'($urandom);
          default: b = 8'((ids.size() != 0) ? ids[$urandom_range(ids.size() - 1)] : $urandom);
        endcase
        it = mk(OP_BYTE, {($urandom_range(3) == 0) ? 24'($urandom) : 24'd0, b},
                0, 0, 0, 0, 0, 0, 0);
        send(noise_fields(it, 0));
        if ($urandom_range(40) == 0)
          send(noise_fields(mk(3'($urandom_range(5, 7)), $urandom, 0, 0, 0, 0, 0, 0, 0), 0));
      end
      if ($urandom_range(9) != 0)
        send(noise_fields(mk(OP_END, $urandom, 0, 0, 0, 0, 0, 0, 0), 0));
      // Sender waits out every result at least once.
      if (phase == 6) drain();
      phase++;
    end
    send(mk(OP_END, 0, 0, 0, 0, 0, 0, 0, 0));
    in_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
hdl/tem_pkg.sv
hdl/tem_datapath.sv
hdl/tem_ctrl.sv
hdl/text_extent_measure_core.sv
hdl/tem_checker.sv
tb/sv/testbench.sv
